@@ rtl/core/cuc_pkg.sv @@
// Shared types, constants and CRC helpers for the chunked image update checker.
`timescale 1ns / 1ps

package cuc_pkg;

    // Geometry of the image and the flash window
    localparam int unsigned CHUNK_BYTES     = 512;
    localparam int unsigned MAX_IMAGE_BYTES = 131072;
    localparam int unsigned FLASH_BASE      = 32'd134479872;

    // Field widths
    localparam int unsigned SIZE_W  = 24;
    localparam int unsigned CHUNK_W = 16;
    localparam int unsigned CRC_W   = 32;
    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned PCT_W   = 7;
    localparam int unsigned CFG_W   = 32;
    localparam int unsigned CFG_IDX_W = 2;

    // Offset must hold CHUNK_BYTES itself so the overrun check can see it
    localparam int unsigned OFS_W = $clog2(CHUNK_BYTES + 1);

    // Progress divider: chunk * 100 over chunk_total, one quotient bit a cycle
    localparam int unsigned PCT_FULL   = 100;
    localparam int unsigned DIVIDEND_W = CHUNK_W + PCT_W;
    localparam int unsigned REM_W      = CHUNK_W + 1;
    localparam int unsigned DIV_STEPS  = DIVIDEND_W;
    localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS + 1);

    localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        ACT_START  = 2'd0,
        ACT_DATA   = 2'd1,
        ACT_FINISH = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_RECV    = 2'd1,
        PH_ERROR   = 2'd2,
        PH_SUCCESS = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        F_NONE       = 3'd0,
        F_SIZE       = 3'd1,
        F_ERASE      = 3'd2,
        F_PROGRAM    = 3'd3,
        F_INCOMPLETE = 3'd4,
        F_CRC        = 3'd5,
        F_OVERRUN    = 3'd6
    } fault_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_SIZE   = 2'd0,
        CFG_CHUNK_TOTAL  = 2'd1,
        CFG_EXPECTED_CRC = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_DIV  = 2'd1,
        ST_DONE = 2'd2
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic apply;     // request accepted: update session state
        logic div_step;  // one progress divider iteration
        logic load_out;  // move the finished result into the output register
    } cuc_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic div_last;  // current divider step is the final one
        logic out_free;  // output register empty or being drained
    } cuc_sts_t;

    // Reflected CRC-32 nibble table, polynomial 0xEDB88320
    function automatic logic [CRC_W-1:0] crc_nib_lut(input logic [3:0] idx);
        logic [CRC_W-1:0] val;
        case (idx)
            4'h0: val = 32'h0000_0000;
            4'h1: val = 32'h1DB7_1064;
            4'h2: val = 32'h3B6E_20C8;
            4'h3: val = 32'h26D9_30AC;
            4'h4: val = 32'h76DC_4190;
            4'h5: val = 32'h6B6B_51F4;
            4'h6: val = 32'h4DB2_6158;
            4'h7: val = 32'h5005_713C;
            4'h8: val = 32'hEDB8_8320;
            4'h9: val = 32'hF00F_9344;
            4'hA: val = 32'hD6D6_A3E8;
            4'hB: val = 32'hCB61_B38C;
            4'hC: val = 32'h9B64_C2B0;
            4'hD: val = 32'h86D3_D2D4;
            4'hE: val = 32'hA00A_E278;
            default: val = 32'hBDBD_F21C;
        endcase
        return val;
    endfunction

    // Fold one byte, low nibble first
    function automatic logic [CRC_W-1:0] crc_fold_byte(input logic [CRC_W-1:0] crc,
                                                      input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc_nib_lut(crc[3:0] ^ b[3:0]) ^ (crc >> 4);
        c = crc_nib_lut(c[3:0] ^ b[7:4]) ^ (c >> 4);
        return c;
    endfunction

endpackage

@@ rtl/core/cuc_ctrl.sv @@
// Sequencer for request acceptance, progress division and result hand-off.
`timescale 1ns / 1ps

module cuc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  cuc_pkg::cuc_sts_t sts,
    output cuc_pkg::cuc_cmd_t cmd
);

    cuc_pkg::ctrl_state_t state_reg;
    cuc_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cuc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            cuc_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.apply  = 1'b1;
                    state_next = cuc_pkg::ST_DIV;
                end
            end
            cuc_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = cuc_pkg::ST_DONE;
                end
            end
            cuc_pkg::ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = cuc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cuc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/cuc_datapath.sv @@
// Session state, CRC, flash address, progress divider and output register.
`timescale 1ns / 1ps

module cuc_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  cuc_pkg::cuc_cmd_t                 cmd,
    output cuc_pkg::cuc_sts_t                 sts,
    input  logic                              cfg_we,
    input  logic [cuc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cuc_pkg::CFG_W-1:0]         cfg_data,
    input  logic [1:0]                        action,
    input  logic [cuc_pkg::CHUNK_W-1:0]       chunk_index,
    input  logic [cuc_pkg::BYTE_W-1:0]        data_byte,
    input  logic                              last_in_chunk,
    input  logic                              erase_ok,
    input  logic                              program_ok,
    input  logic                              out_stall,
    output logic                              out_valid,
    output logic                              accepted,
    output logic [1:0]                        phase,
    output logic [2:0]                        fault_reason,
    output logic                              write_enable,
    output logic [cuc_pkg::ADDR_W-1:0]        write_address,
    output logic [cuc_pkg::BYTE_W-1:0]        write_data,
    output logic [cuc_pkg::PCT_W-1:0]         progress_percent,
    output logic [cuc_pkg::CRC_W-1:0]         computed_crc
);

    // configuration
    logic [cuc_pkg::SIZE_W-1:0]  image_size_reg;
    logic [cuc_pkg::CHUNK_W-1:0] chunk_total_reg;
    logic [cuc_pkg::CRC_W-1:0]   expected_crc_reg;

    // session state
    cuc_pkg::phase_t             phase_reg, phase_next;
    cuc_pkg::fault_t             fault_reg, fault_next;
    logic [cuc_pkg::CHUNK_W-1:0] chunk_reg, chunk_next;
    logic [cuc_pkg::OFS_W-1:0]   offset_reg, offset_next;
    logic [cuc_pkg::CRC_W-1:0]   crc_reg, crc_next;

    // per-request result fields
    logic                        res_acc_reg, res_acc_next;
    cuc_pkg::fault_t             res_fault_reg, res_fault_next;
    logic                        res_we_reg, res_we_next;
    logic [cuc_pkg::ADDR_W-1:0]  res_addr_reg, res_addr_next;
    logic [cuc_pkg::BYTE_W-1:0]  res_data_reg, res_data_next;

    // progress divider
    logic [cuc_pkg::DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [cuc_pkg::REM_W-1:0]      rem_reg, rem_next;
    logic [cuc_pkg::DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [cuc_pkg::REM_W-1:0]      rem_shift;
    logic [cuc_pkg::REM_W-1:0]      divisor;
    logic                           quo_bit;
    logic [cuc_pkg::PCT_W-1:0]      pct_val;

    // output register
    logic                        out_valid_reg;
    logic                        out_acc_reg;
    cuc_pkg::phase_t             out_phase_reg;
    cuc_pkg::fault_t             out_fault_reg;
    logic                        out_we_reg;
    logic [cuc_pkg::ADDR_W-1:0]  out_addr_reg;
    logic [cuc_pkg::BYTE_W-1:0]  out_data_reg;
    logic [cuc_pkg::PCT_W-1:0]   out_pct_reg;
    logic [cuc_pkg::CRC_W-1:0]   out_crc_reg;

    logic [cuc_pkg::ADDR_W-1:0]  byte_addr;
    logic                        size_bad;

    assign byte_addr = cuc_pkg::ADDR_W'(cuc_pkg::FLASH_BASE)
                     + cuc_pkg::ADDR_W'(chunk_reg) * cuc_pkg::ADDR_W'(cuc_pkg::CHUNK_BYTES)
                     + cuc_pkg::ADDR_W'(offset_reg);

    assign size_bad = (image_size_reg == '0)
                   || (image_size_reg > cuc_pkg::SIZE_W'(cuc_pkg::MAX_IMAGE_BYTES));

    // session update for one request
    always_comb
    begin
        phase_next     = phase_reg;
        fault_next     = fault_reg;
        chunk_next     = chunk_reg;
        offset_next    = offset_reg;
        crc_next       = crc_reg;
        res_acc_next   = 1'b0;
        res_we_next    = 1'b0;
        res_addr_next  = '0;
        res_data_next  = '0;
        res_fault_next = fault_reg;
        unique case (cuc_pkg::action_t'(action))
            cuc_pkg::ACT_START:
            begin
                if (phase_reg != cuc_pkg::PH_RECV)
                begin
                    res_acc_next = 1'b1;
                    chunk_next   = '0;
                    if (size_bad)
                    begin
                        phase_next = cuc_pkg::PH_ERROR;
                        fault_next = cuc_pkg::F_SIZE;
                    end
                    else if (!erase_ok)
                    begin
                        phase_next = cuc_pkg::PH_ERROR;
                        fault_next = cuc_pkg::F_ERASE;
                    end
                    else
                    begin
                        phase_next  = cuc_pkg::PH_RECV;
                        fault_next  = cuc_pkg::F_NONE;
                        offset_next = '0;
                        crc_next    = cuc_pkg::CRC_INIT;
                    end
                end
                res_fault_next = fault_next;
            end
            cuc_pkg::ACT_DATA:
            begin
                if (phase_reg == cuc_pkg::PH_RECV && chunk_index == chunk_reg)
                begin
                    if (offset_reg >= cuc_pkg::OFS_W'(cuc_pkg::CHUNK_BYTES))
                    begin
                        // overrun: reported for this request, state untouched
                        res_fault_next = cuc_pkg::F_OVERRUN;
                    end
                    else
                    begin
                        res_acc_next  = 1'b1;
                        res_we_next   = 1'b1;
                        res_addr_next = byte_addr;
                        res_data_next = data_byte;
                        if (!program_ok)
                        begin
                            phase_next = cuc_pkg::PH_ERROR;
                            fault_next = cuc_pkg::F_PROGRAM;
                        end
                        else
                        begin
                            crc_next = cuc_pkg::crc_fold_byte(crc_reg, data_byte);
                            if (last_in_chunk)
                            begin
                                chunk_next  = chunk_reg + 1'b1;
                                offset_next = '0;
                            end
                            else
                            begin
                                offset_next = offset_reg + 1'b1;
                            end
                        end
                        res_fault_next = fault_next;
                    end
                end
            end
            cuc_pkg::ACT_FINISH:
            begin
                if (phase_reg == cuc_pkg::PH_RECV)
                begin
                    res_acc_next = 1'b1;
                    if (chunk_reg != chunk_total_reg)
                    begin
                        phase_next = cuc_pkg::PH_ERROR;
                        fault_next = cuc_pkg::F_INCOMPLETE;
                    end
                    else if (~crc_reg != expected_crc_reg)
                    begin
                        phase_next = cuc_pkg::PH_ERROR;
                        fault_next = cuc_pkg::F_CRC;
                    end
                    else
                    begin
                        phase_next = cuc_pkg::PH_SUCCESS;
                        fault_next = cuc_pkg::F_NONE;
                    end
                end
                res_fault_next = fault_next;
            end
            default:
            begin
                res_fault_next = fault_reg;
            end
        endcase
    end

    // restoring divider, one quotient bit per step
    assign divisor   = {1'b0, chunk_total_reg};
    assign rem_shift = {rem_reg[cuc_pkg::REM_W-2:0], quo_reg[cuc_pkg::DIVIDEND_W-1]};
    assign quo_bit   = (rem_shift >= divisor);

    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        if (cmd.apply)
        begin
            quo_next = cuc_pkg::DIVIDEND_W'(chunk_next)
                     * cuc_pkg::DIVIDEND_W'(cuc_pkg::PCT_FULL);
            rem_next = '0;
            cnt_next = '0;
        end
        else if (cmd.div_step)
        begin
            quo_next = {quo_reg[cuc_pkg::DIVIDEND_W-2:0], quo_bit};
            rem_next = quo_bit ? (rem_shift - divisor) : rem_shift;
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_comb
    begin
        if (chunk_total_reg == '0)
        begin
            pct_val = '0;
        end
        else if (quo_reg > cuc_pkg::DIVIDEND_W'(cuc_pkg::PCT_FULL))
        begin
            pct_val = cuc_pkg::PCT_W'(cuc_pkg::PCT_FULL);
        end
        else
        begin
            pct_val = quo_reg[cuc_pkg::PCT_W-1:0];
        end
    end

    assign sts.div_last = (cnt_reg == cuc_pkg::DIV_CNT_W'(cuc_pkg::DIV_STEPS - 1));
    assign sts.out_free = !out_valid_reg || !out_stall;

    // control and session registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_size_reg   <= '0;
            chunk_total_reg  <= '0;
            expected_crc_reg <= '0;
            phase_reg        <= cuc_pkg::PH_IDLE;
            fault_reg        <= cuc_pkg::F_NONE;
            chunk_reg        <= '0;
            offset_reg       <= '0;
            crc_reg          <= cuc_pkg::CRC_INIT;
            cnt_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cuc_pkg::cfg_idx_t'(cfg_index))
                    cuc_pkg::CFG_IMAGE_SIZE:   image_size_reg   <= cfg_data[cuc_pkg::SIZE_W-1:0];
                    cuc_pkg::CFG_CHUNK_TOTAL:  chunk_total_reg  <= cfg_data[cuc_pkg::CHUNK_W-1:0];
                    cuc_pkg::CFG_EXPECTED_CRC: expected_crc_reg <= cfg_data[cuc_pkg::CRC_W-1:0];
                    default:                   ;
                endcase
            end
            if (cmd.apply)
            begin
                phase_reg  <= phase_next;
                fault_reg  <= fault_next;
                chunk_reg  <= chunk_next;
                offset_reg <= offset_next;
                crc_reg    <= crc_next;
            end
            cnt_reg <= cnt_next;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (cmd.apply)
        begin
            res_acc_reg   <= res_acc_next;
            res_fault_reg <= res_fault_next;
            res_we_reg    <= res_we_next;
            res_addr_reg  <= res_addr_next;
            res_data_reg  <= res_data_next;
        end
        if (cmd.load_out)
        begin
            out_acc_reg   <= res_acc_reg;
            out_phase_reg <= phase_reg;
            out_fault_reg <= res_fault_reg;
            out_we_reg    <= res_we_reg;
            out_addr_reg  <= res_addr_reg;
            out_data_reg  <= res_data_reg;
            out_pct_reg   <= pct_val;
            out_crc_reg   <= ~crc_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign accepted         = out_acc_reg;
    assign phase            = out_phase_reg;
    assign fault_reason     = out_fault_reg;
    assign write_enable     = out_we_reg;
    assign write_address    = out_addr_reg;
    assign write_data       = out_data_reg;
    assign progress_percent = out_pct_reg;
    assign computed_crc     = out_crc_reg;

    a_write_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_we_reg |-> out_acc_reg)
        else $error("flash write issued on a rejected request");

    a_pct_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_pct_reg <= cuc_pkg::PCT_W'(cuc_pkg::PCT_FULL))
        else $error("progress above full scale");

    a_overrun_rejected: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_fault_reg == cuc_pkg::F_OVERRUN |-> !out_acc_reg && !out_we_reg)
        else $error("overrun byte was taken");

    a_success_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_phase_reg == cuc_pkg::PH_SUCCESS
            |-> out_fault_reg == cuc_pkg::F_NONE)
        else $error("success reported with a fault");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !out_valid_reg || !out_stall)
        else $error("output register overwritten while held");

endmodule

@@ rtl/core/chunked_image_update_checker.sv @@
// Top level of the chunked image update checker: controller plus datapath.
`timescale 1ns / 1ps

// Checks an in-order chunked image download. A start request validates the
// configured image size and the erase status and opens a session; each data
// request that matches the expected chunk and does not overrun it yields one
// flash byte write at base + chunk * chunk size + offset and, if program_ok
// holds, is folded into a reflected CRC-32; a finish request compares chunk
// count and CRC against the configured values. Every request gives exactly
// one result. The session update happens at the accepting edge; then the
// bit-serial restoring divider forms the progress percentage, and the result
// is loaded into the output register once that register is free. The next
// request is taken only after that load. A result waiting on out_stall does
// not hold up the next request until its own result is ready. Configuration
// registers (0 image size, 1 chunk total, 2 expected CRC) are written through
// cfg_we/cfg_index/cfg_data; the user must write them only while no request
// is in flight, which the block does not enforce; index 3 is ignored.

module chunked_image_update_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_we,
    input  logic [cuc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cuc_pkg::CFG_W-1:0]     cfg_data,
    // request channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    action,
    input  logic [cuc_pkg::CHUNK_W-1:0]   chunk_index,
    input  logic [cuc_pkg::BYTE_W-1:0]    data_byte,
    input  logic                          last_in_chunk,
    input  logic                          erase_ok,
    input  logic                          program_ok,
    // result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          accepted,
    output logic [1:0]                    phase,
    output logic [2:0]                    fault_reason,
    output logic                          write_enable,
    output logic [cuc_pkg::ADDR_W-1:0]    write_address,
    output logic [cuc_pkg::BYTE_W-1:0]    write_data,
    output logic [cuc_pkg::PCT_W-1:0]     progress_percent,
    output logic [cuc_pkg::CRC_W-1:0]     computed_crc
);

    cuc_pkg::cuc_cmd_t cmd;  // sequencer commands
    cuc_pkg::cuc_sts_t sts;  // divider / output register status

    // Sequencer: idle -> divide -> hand off
    cuc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Session state, CRC, address, divider and output register
    cuc_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .action           (action),
        .chunk_index      (chunk_index),
        .data_byte        (data_byte),
        .last_in_chunk    (last_in_chunk),
        .erase_ok         (erase_ok),
        .program_ok       (program_ok),
        .out_stall        (out_stall),
        .out_valid        (out_valid),
        .accepted         (accepted),
        .phase            (phase),
        .fault_reason     (fault_reason),
        .write_enable     (write_enable),
        .write_address    (write_address),
        .write_data       (write_data),
        .progress_percent (progress_percent),
        .computed_crc     (computed_crc)
    );

endmodule
